// File: hdl/she_pkg.sv
// shared types and constants for the symbol histogram entropy block
// no dependencies; imported by every module of the block
`default_nettype none

package she_pkg;

  localparam int SYMBOL_BITS   = 8;
  localparam int COUNT_BITS    = 32;
  localparam int FRAC_BITS     = 16;
  localparam int NUM_BINS      = 1 << SYMBOL_BITS;
  localparam int MANT_FRAC     = 30;
  localparam int MANT_BITS     = MANT_FRAC + 1;
  localparam int LOG_INT_BITS  = $clog2(COUNT_BITS);
  localparam int LOG_BITS      = LOG_INT_BITS + FRAC_BITS;
  localparam int ITER_BITS     = $clog2(FRAC_BITS);
  localparam int SUM_BITS      = 64;
  localparam int PROD_BITS     = COUNT_BITS + LOG_BITS;
  localparam int DIV_CNT_BITS  = $clog2(SUM_BITS);
  localparam int ENT_BITS      = 20;
  localparam int SYM_PORT_BITS = 8;
  localparam int TOTAL_BITS    = 32;
  localparam int OUT_DATA_BITS = ((ENT_BITS + TOTAL_BITS + 7) / 8) * 8;

  localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};
  localparam logic [LOG_BITS-1:0]   ENT_MAX   = LOG_BITS'(SYMBOL_BITS << FRAC_BITS);

  // commands from the controller to the datapath
  typedef struct packed {
    logic accept;     // capture item, count it, read its bin
    logic upd;        // write back incremented bin
    logic walk_clr;   // bin index to zero
    logic bin_next;   // bin index plus one
    logic walk_take;  // latch the bin count just read
    logic log_bin;    // start log2 on the bin count just read
    logic log_n;      // start log2 on the frame total
    logic mul;        // count times log2
    logic acc;        // add product into the sum
    logic logn_take;  // keep log2 of the total
    logic div_start;  // start sum / total
    logic finish;     // load result and clear the frame
  } cmd_t;

  // status back to the controller
  typedef struct packed {
    logic last;       // captured item ends the frame
    logic c_zero;     // bin count just read is zero
    logic bin_last;   // bin index at the final bin
    logic log_done;
    logic div_done;
    logic out_full;   // result register still waits to be taken
  } sts_t;

endpackage

`default_nettype wire

// File: hdl/she_log2.sv
// iterative fixed-point log2: one-bit-a-cycle normalize, then one squaring per fraction bit
// depends on she_pkg
`default_nettype none

module she_log2 (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic [she_pkg::COUNT_BITS-1:0] x_i,
  output logic                         done_o,
  output logic [she_pkg::LOG_BITS-1:0] result_o
);
  import she_pkg::*;

  typedef enum logic [1:0] {L_IDLE, L_NORM, L_SQ, L_ADJ} lstate_e;

  lstate_e                  state_q;
  logic                     done_q;
  logic [COUNT_BITS-1:0]    m_q;
  logic [LOG_INT_BITS-1:0]  p_q;
  logic [MANT_BITS-1:0]     mant_q;
  logic [2*MANT_BITS-1:0]   prod_q;
  logic [FRAC_BITS-1:0]     frac_q;
  logic [ITER_BITS-1:0]     it_q;
  logic [MANT_FRAC+1:0]     sq;

  // square with the low fraction bits dropped, value in [1,4)
  assign sq = prod_q[MANT_FRAC +: MANT_FRAC+2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= L_IDLE;
      done_q  <= 1'b0;
    end else begin
      done_q <= 1'b0;
      unique case (state_q)
        L_IDLE: if (start_i) state_q <= L_NORM;
        L_NORM: if (m_q[COUNT_BITS-1] || p_q == '0) state_q <= L_SQ;
        L_SQ:   state_q <= L_ADJ;
        L_ADJ: begin
          if (it_q == '0) begin
            state_q <= L_IDLE;
            done_q  <= 1'b1;
          end else begin
            state_q <= L_SQ;
          end
        end
        default: state_q <= L_IDLE;
      endcase
    end
  end

  // result holds in idle until the next start
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      L_IDLE: begin
        if (start_i) begin
          m_q <= x_i;
          p_q <= LOG_INT_BITS'(COUNT_BITS - 1);
        end
      end
      L_NORM: begin
        if (m_q[COUNT_BITS-1] || p_q == '0) begin
          mant_q <= m_q[COUNT_BITS-1 -: MANT_BITS];
          it_q   <= ITER_BITS'(FRAC_BITS - 1);
          frac_q <= '0;
        end else begin
          m_q <= {m_q[COUNT_BITS-2:0], 1'b0};
          p_q <= p_q - 1'b1;
        end
      end
      L_SQ: prod_q <= mant_q * mant_q;
      L_ADJ: begin
        if (sq[MANT_FRAC+1]) begin
          mant_q <= sq[MANT_FRAC+1:1];
          frac_q <= {frac_q[FRAC_BITS-2:0], 1'b1};
        end else begin
          mant_q <= sq[MANT_FRAC:0];
          frac_q <= {frac_q[FRAC_BITS-2:0], 1'b0};
        end
        it_q <= it_q - 1'b1;
      end
      default: ;
    endcase
  end

  assign done_o   = done_q;
  assign result_o = {p_q, frac_q};

endmodule

`default_nettype wire

// File: hdl/she_div.sv
// restoring divider, one quotient bit per cycle, sum by frame total
// depends on she_pkg
`default_nettype none

module she_div (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [she_pkg::SUM_BITS-1:0]  dividend_i,
  input  logic [she_pkg::COUNT_BITS-1:0] divisor_i,
  output logic                          done_o,
  output logic [she_pkg::SUM_BITS-1:0]  quotient_o
);
  import she_pkg::*;

  logic                    busy_q;
  logic                    done_q;
  logic [DIV_CNT_BITS-1:0] cnt_q;
  logic [COUNT_BITS-1:0]   rem_q;
  logic [COUNT_BITS-1:0]   dvs_q;
  logic [SUM_BITS-1:0]     quo_q;
  logic [COUNT_BITS:0]     r_sh;
  logic                    fits;

  assign r_sh = {rem_q, quo_q[SUM_BITS-1]};
  assign fits = r_sh >= {1'b0, dvs_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
      end else if (busy_q && cnt_q == '0) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      quo_q <= dividend_i;
      dvs_q <= divisor_i;
      cnt_q <= DIV_CNT_BITS'(SUM_BITS - 1);
    end else if (busy_q) begin
      rem_q <= fits ? COUNT_BITS'(r_sh - {1'b0, dvs_q}) : r_sh[COUNT_BITS-1:0];
      quo_q <= {quo_q[SUM_BITS-2:0], fits};
      cnt_q <= cnt_q - 1'b1;
    end
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

`default_nettype wire

// File: hdl/she_datapath.sv
// histogram memory, counters, weighted log sum and result register
// depends on she_pkg, she_log2, she_div
`default_nettype none

module she_datapath (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  she_pkg::cmd_t                  cmd_i,
  output she_pkg::sts_t                  sts_o,
  input  logic [she_pkg::SYM_PORT_BITS-1:0] sym_i,
  input  logic                           last_i,
  input  logic                           out_ready_i,
  output logic                           out_valid_o,
  output logic [she_pkg::ENT_BITS-1:0]   entropy_o,
  output logic [she_pkg::TOTAL_BITS-1:0] total_o,
  output logic                           ovf_o
);
  import she_pkg::*;

  logic [COUNT_BITS-1:0]  mem [NUM_BINS];
  logic [NUM_BINS-1:0]    valid_q;
  logic [COUNT_BITS-1:0]  rd_q;
  logic                   rdv_q;
  logic [SYMBOL_BITS-1:0] rd_addr;
  logic [SYMBOL_BITS-1:0] sym_q;
  logic                   last_q;
  logic [SYMBOL_BITS-1:0] bin_q;
  logic [COUNT_BITS-1:0]  total_q;
  logic                   sat_q;
  logic [COUNT_BITS-1:0]  cur;
  logic [COUNT_BITS-1:0]  c_q;
  logic [PROD_BITS-1:0]   prod_q;
  logic [SUM_BITS-1:0]    sum_q;
  logic [LOG_BITS-1:0]    logn_q;
  logic                   out_valid_q;
  logic [ENT_BITS-1:0]    ent_q;
  logic [TOTAL_BITS-1:0]  tot_q;
  logic                   ovf_q;
  logic                   log_start;
  logic [COUNT_BITS-1:0]  log_x;
  logic                   log_done;
  logic [LOG_BITS-1:0]    log_res;
  logic                   div_done;
  logic [SUM_BITS-1:0]    quot;
  logic [LOG_BITS-1:0]    h;
  logic [LOG_BITS-1:0]    h_clamp;

  assign rd_addr = cmd_i.accept ? sym_i[SYMBOL_BITS-1:0] : bin_q;
  assign cur     = rdv_q ? rd_q : '0;

  always_ff @(posedge clk_i) begin
    rd_q <= mem[rd_addr];
    if (cmd_i.upd) begin
      mem[sym_q] <= (cur == COUNT_MAX) ? cur : cur + 1'b1;
    end
  end

  assign log_start = cmd_i.log_bin | cmd_i.log_n;
  assign log_x     = cmd_i.log_n ? total_q : cur;

  she_log2 u_log2 (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (log_start),
    .x_i      (log_x),
    .done_o   (log_done),
    .result_o (log_res)
  );

  she_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (sum_q),
    .divisor_i  (total_q),
    .done_o     (div_done),
    .quotient_o (quot)
  );

  // negative entropy only after saturation, then zero; clamp at the bound
  assign h       = (quot > SUM_BITS'(logn_q)) ? '0 : logn_q - quot[LOG_BITS-1:0];
  assign h_clamp = (h > ENT_MAX) ? ENT_MAX : h;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q     <= '0;
      rdv_q       <= 1'b0;
      total_q     <= '0;
      sat_q       <= 1'b0;
      sum_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      rdv_q <= valid_q[rd_addr];
      if (cmd_i.accept) begin
        if (total_q == COUNT_MAX) sat_q <= 1'b1;
        else total_q <= total_q + 1'b1;
      end
      if (cmd_i.upd) begin
        valid_q[sym_q] <= 1'b1;
        if (cur == COUNT_MAX) sat_q <= 1'b1;
      end
      // product is below 2^53, so no bin walk can carry out of the sum
      if (cmd_i.acc) sum_q <= sum_q + SUM_BITS'(prod_q);
      if (out_valid_q && out_ready_i) out_valid_q <= 1'b0;
      if (cmd_i.finish) begin
        out_valid_q <= 1'b1;
        valid_q     <= '0;
        total_q     <= '0;
        sat_q       <= 1'b0;
        sum_q       <= '0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      sym_q  <= sym_i[SYMBOL_BITS-1:0];
      last_q <= last_i;
    end
    if (cmd_i.walk_clr) bin_q <= '0;
    else if (cmd_i.bin_next) bin_q <= bin_q + 1'b1;
    if (cmd_i.walk_take) c_q <= cur;
    if (cmd_i.mul) prod_q <= c_q * log_res;
    if (cmd_i.logn_take) logn_q <= log_res;
    if (cmd_i.finish) begin
      ent_q <= h_clamp[ENT_BITS-1:0];
      tot_q <= TOTAL_BITS'(total_q);
      ovf_q <= sat_q;
    end
  end

  assign sts_o.last     = last_q;
  assign sts_o.c_zero   = (cur == '0);
  assign sts_o.bin_last = (bin_q == SYMBOL_BITS'(NUM_BINS - 1));
  assign sts_o.log_done = log_done;
  assign sts_o.div_done = div_done;
  assign sts_o.out_full = out_valid_q;

  assign out_valid_o = out_valid_q;
  assign entropy_o   = ent_q;
  assign total_o     = tot_q;
  assign ovf_o       = ovf_q;

endmodule

`default_nettype wire

// File: hdl/she_ctrl.sv
// controller: counting phase, bin walk, log of total, divide, result load
// depends on she_pkg
`default_nettype none

module she_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  output she_pkg::cmd_t cmd_o,
  input  she_pkg::sts_t sts_i
);
  import she_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_UPD, S_WRD, S_WTAKE, S_LOGB, S_MUL, S_ACC, S_LOGN, S_DIV, S_FIN
  } state_e;

  state_e state_q, state_d;
  cmd_t   cmd;

  assign in_ready_o = (state_q == S_IDLE);

  always_comb begin
    cmd     = '0;
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd.accept = 1'b1;
          state_d    = S_UPD;
        end
      end
      S_UPD: begin
        cmd.upd = 1'b1;
        if (sts_i.last) begin
          cmd.walk_clr = 1'b1;
          state_d      = S_WRD;
        end else begin
          state_d = S_IDLE;
        end
      end
      S_WRD: state_d = S_WTAKE;
      S_WTAKE: begin
        cmd.walk_take = 1'b1;
        priority if (!sts_i.c_zero) begin
          cmd.log_bin = 1'b1;
          state_d     = S_LOGB;
        end else if (sts_i.bin_last) begin
          cmd.log_n = 1'b1;
          state_d   = S_LOGN;
        end else begin
          cmd.bin_next = 1'b1;
          state_d      = S_WRD;
        end
      end
      S_LOGB: if (sts_i.log_done) state_d = S_MUL;
      S_MUL: begin
        cmd.mul = 1'b1;
        state_d = S_ACC;
      end
      S_ACC: begin
        cmd.acc = 1'b1;
        if (sts_i.bin_last) begin
          cmd.log_n = 1'b1;
          state_d   = S_LOGN;
        end else begin
          cmd.bin_next = 1'b1;
          state_d      = S_WRD;
        end
      end
      S_LOGN: begin
        if (sts_i.log_done) begin
          cmd.logn_take = 1'b1;
          cmd.div_start = 1'b1;
          state_d       = S_DIV;
        end
      end
      S_DIV: if (sts_i.div_done) state_d = S_FIN;
      S_FIN: begin
        if (!sts_i.out_full) begin
          cmd.finish = 1'b1;
          state_d    = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  assign cmd_o = cmd;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire

// File: hdl/symbol_histogram_entropy_top.sv
// top level of the zero-order entropy block: controller plus datapath
// depends on she_pkg, she_ctrl, she_datapath
`default_nettype none

// Counts a stream of 8-bit symbols into a 256-bin histogram and, on the beat
// that carries tlast, emits the frame's zero-order entropy in bits per symbol
// (16 fraction bits), the saturating symbol count and an overflow flag, then
// starts a fresh frame. For each symbol beat the block reads its bin from the
// histogram memory, then writes it back incremented before it takes the next
// beat. At frame end the block walks all 256 bins; each filled bin also runs
// the shared log2 unit, which does one squaring per fraction bit. Log2 of the
// total follows, then a restoring divide of the weighted sum by the total. The
// result sits in an output register; a new frame may be counted while it
// waits, but the next frame end holds until it is taken. No clearing pass is
// needed after reset: per-bin valid flags make empty bins read as zero.

module symbol_histogram_entropy_top (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                s_axis_tvalid_i,
  output logic                                s_axis_tready_o,
  input  logic [she_pkg::SYM_PORT_BITS-1:0]   s_axis_tdata_i,  // [7:0] symbol
  input  logic                                s_axis_tlast_i,  // last symbol of frame
  output logic                                m_axis_tvalid_o,
  input  logic                                m_axis_tready_i,
  // [19:0] entropy_fixed, [51:20] symbol_total, [55:52] zero
  output logic [she_pkg::OUT_DATA_BITS-1:0]   m_axis_tdata_o,
  output logic                                m_axis_tuser_o   // [0] count_overflow
);
  import she_pkg::*;

  cmd_t                  cmd;
  sts_t                  sts;
  logic [ENT_BITS-1:0]   entropy;
  logic [TOTAL_BITS-1:0] total;

  she_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_ready_o (s_axis_tready_o),
    .cmd_o      (cmd),
    .sts_i      (sts)
  );

  she_datapath u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .sym_i       (s_axis_tdata_i),
    .last_i      (s_axis_tlast_i),
    .out_ready_i (m_axis_tready_i),
    .out_valid_o (m_axis_tvalid_o),
    .entropy_o   (entropy),
    .total_o     (total),
    .ovf_o       (m_axis_tuser_o)
  );

  // pack result beat, first field lowest
  assign m_axis_tdata_o = {{(OUT_DATA_BITS - ENT_BITS - TOTAL_BITS){1'b0}}, total, entropy};

endmodule

`default_nettype wire

// File: hdl/she_checker.sv
// port-level checks for the entropy block, bound to the top level
// depends on she_pkg, symbol_histogram_entropy_top
`default_nettype none

module she_checker (
  input logic                                clk_i,
  input logic                                rst_ni,
  input logic                                s_axis_tready_o,
  input logic                                m_axis_tvalid_o,
  input logic                                m_axis_tready_i,
  input logic [she_pkg::OUT_DATA_BITS-1:0]   m_axis_tdata_o,
  input logic                                m_axis_tuser_o
);
  import she_pkg::*;

  // no result beat while in reset
  a_reset_quiet: assert property (@(posedge clk_i) !rst_ni |-> !m_axis_tvalid_o)
    else $error("result beat shown during reset");

  // stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o && $stable(m_axis_tdata_o))
    else $error("stalled result changed");

  // entropy never above log2 of the alphabet size, count never zero
  a_bounds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> (m_axis_tdata_o[ENT_BITS-1:0] <= ENT_MAX[ENT_BITS-1:0])
      && (m_axis_tdata_o[ENT_BITS +: TOTAL_BITS] != '0))
    else $error("result out of range");

  // a bin can only saturate once the total has
  a_ovf_total: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tuser_o |-> m_axis_tdata_o[ENT_BITS +: TOTAL_BITS] == '1)
    else $error("overflow flag without saturated total");

  // new result appears only when the input side is closed
  a_rise_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid_o) |-> !$past(s_axis_tready_o))
    else $error("result appeared while counting");

endmodule

bind symbol_histogram_entropy_top she_checker u_she_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tready_o (s_axis_tready_o),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o),
  .m_axis_tuser_o  (m_axis_tuser_o)
);

`default_nettype wire

// File: tb/symbol_histogram_entropy_top_test.sv
// testbench for the zero-order entropy block: directed and random symbol frames
// depends on she_pkg and symbol_histogram_entropy_top; predicts every result itself
`default_nettype none

module symbol_histogram_entropy_top_test;
  timeunit 1ns;
  timeprecision 1ps;

  import she_pkg::*;

  localparam int WATCHDOG_LIMIT = 200000;

  // traffic shaping modes
  typedef enum int {
    IDLE_NONE,
    IDLE_SEND,
    IDLE_RECV,
    IDLE_BOTH
  } idle_mode_e;

  typedef struct {
    logic [ENT_BITS-1:0]   entropy;
    logic [TOTAL_BITS-1:0] total;
    logic                  overflow;
  } frame_result_t;

  logic                     clk_i = 1'b0;
  logic                     rst_ni = 1'b0;
  logic                     s_axis_tvalid_i = 1'b0;
  logic                     s_axis_tready_o;
  logic [SYM_PORT_BITS-1:0] s_axis_tdata_i = '0;
  logic                     s_axis_tlast_i = 1'b0;
  logic                     m_axis_tvalid_o;
  logic                     m_axis_tready_i = 1'b0;
  logic [OUT_DATA_BITS-1:0] m_axis_tdata_o;
  logic                     m_axis_tuser_o;

  symbol_histogram_entropy_top u_top (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tlast_i  (s_axis_tlast_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o)
  );

  always #1 clk_i = ~clk_i;

  // predictor state: histogram, frame count, saturation flag
  longint unsigned hist_bins [NUM_BINS];
  longint unsigned frame_syms;
  bit              frame_sat;

  frame_result_t expected_frames [$];
  idle_mode_e    idle_mode = IDLE_NONE;
  int            error_count = 0;
  int            idle_count = 0;

  // fixed-point log2: integer part from the top bit, fraction by repeated squaring
  function automatic longint unsigned fixed_log2(longint unsigned x);
    longint unsigned mant, res;
    int              top;
    top = 0;
    if (x == 0) return 0;
    for (int b = 0; b < 64; b++) if (x[b]) top = b;
    if (top > MANT_FRAC) mant = x >> (top - MANT_FRAC);
    else mant = x << (MANT_FRAC - top);
    res = longint'(top) << FRAC_BITS;
    for (int i = FRAC_BITS - 1; i >= 0; i--) begin
      mant = (mant * mant) >> MANT_FRAC;
      if (mant >= (64'd2 << MANT_FRAC)) begin
        mant = mant >> 1;
        res[i] = 1'b1;
      end
    end
    return res;
  endfunction

  // count one accepted symbol and, at frame end, queue the predicted result
  task automatic count_symbol(input logic [SYM_PORT_BITS-1:0] sym, input logic last);
    longint unsigned cmax, wsum, lg, term, logn, quot, h;
    frame_result_t   res;
    cmax = (64'd1 << COUNT_BITS) - 1;
    if (frame_syms < cmax) frame_syms++;
    else frame_sat = 1'b1;
    if (hist_bins[sym] < cmax) hist_bins[sym]++;
    else frame_sat = 1'b1;
    if (!last) return;
    wsum = 0;
    for (int b = 0; b < NUM_BINS; b++) begin
      if (hist_bins[b] != 0) begin
        lg = fixed_log2(hist_bins[b]);
        if (lg != 0 && hist_bins[b] > 64'hFFFF_FFFF_FFFF_FFFF / lg) begin
          wsum = 64'hFFFF_FFFF_FFFF_FFFF;
        end else begin
          term = hist_bins[b] * lg;
          if (wsum > 64'hFFFF_FFFF_FFFF_FFFF - term) wsum = 64'hFFFF_FFFF_FFFF_FFFF;
          else wsum = wsum + term;
        end
      end
    end
    logn = fixed_log2(frame_syms);
    quot = wsum / frame_syms;
    h = (quot > logn) ? 0 : logn - quot;
    if (h > (longint'(SYMBOL_BITS) << FRAC_BITS)) h = longint'(SYMBOL_BITS) << FRAC_BITS;
    res.entropy  = h[ENT_BITS-1:0];
    res.total    = frame_syms[TOTAL_BITS-1:0];
    res.overflow = frame_sat;
    expected_frames.push_back(res);
    foreach (hist_bins[b]) hist_bins[b] = 0;
    frame_syms = 0;
    frame_sat  = 1'b0;
  endtask

  // drive one symbol beat, with a random gap before it in the idling phases
  task automatic send_symbol(input logic [SYM_PORT_BITS-1:0] sym, input logic last);
    int pct;
    pct = (idle_mode == IDLE_SEND) ? 71 : (idle_mode == IDLE_BOTH) ? 30 : 0;
    @(negedge clk_i);
    while ($urandom_range(99) < pct) begin
      s_axis_tvalid_i = 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid_i = 1'b1;
    s_axis_tdata_i  = sym;
    s_axis_tlast_i  = last;
    do @(posedge clk_i); while (!s_axis_tready_o);
    count_symbol(sym, last);
  endtask

  // receiver stall pattern follows the current phase
  always @(negedge clk_i) begin
    int pct;
    pct = (idle_mode == IDLE_RECV) ? 71 : (idle_mode == IDLE_BOTH) ? 30 : 0;
    m_axis_tready_i <= ($urandom_range(99) >= pct);
  end

  // result checker: each accepted beat against the oldest prediction
  always @(posedge clk_i) begin
    frame_result_t exp_res;
    if (m_axis_tvalid_o && m_axis_tready_i) begin
      if (expected_frames.size() == 0) begin
        $display("%0t: unexpected result beat, actual data %h user %b",
                 $time, m_axis_tdata_o, m_axis_tuser_o);
        error_count++;
      end else begin
        exp_res = expected_frames.pop_front();
        if (m_axis_tdata_o[ENT_BITS-1:0] !== exp_res.entropy) begin
          $display("%0t: entropy expected %h actual %h", $time, exp_res.entropy,
                   m_axis_tdata_o[ENT_BITS-1:0]);
          error_count++;
        end
        if (m_axis_tdata_o[ENT_BITS+TOTAL_BITS-1:ENT_BITS] !== exp_res.total) begin
          $display("%0t: total expected %0d actual %0d", $time, exp_res.total,
                   m_axis_tdata_o[ENT_BITS+TOTAL_BITS-1:ENT_BITS]);
          error_count++;
        end
        if (m_axis_tdata_o[OUT_DATA_BITS-1:ENT_BITS+TOTAL_BITS] !== '0) begin
          $display("%0t: pad bits expected 0 actual %h", $time,
                   m_axis_tdata_o[OUT_DATA_BITS-1:ENT_BITS+TOTAL_BITS]);
          error_count++;
        end
        if (m_axis_tuser_o !== exp_res.overflow) begin
          $display("%0t: overflow expected %b actual %b", $time, exp_res.overflow,
                   m_axis_tuser_o);
          error_count++;
        end
      end
    end
  end

  // watchdog: too long without any beat on either side
  always @(posedge clk_i) begin
    if ((s_axis_tvalid_i && s_axis_tready_o) || (m_axis_tvalid_o && m_axis_tready_i))
      idle_count <= 0;
    else if (rst_ni) idle_count <= idle_count + 1;
    if (idle_count >= WATCHDOG_LIMIT) begin
      $display("%0t: watchdog expired", $time);
      $display("** symbol_histogram_entropy_top: FAILED **");
      $finish;
    end
  end

  // corner frames: single symbol, even split, extreme symbols, one repeated symbol, uneven split
  task automatic test_directed();
    send_symbol(8'h00, 1'b1);
    send_symbol(8'hFF, 1'b1);
    send_symbol(8'h00, 1'b0);
    send_symbol(8'hFF, 1'b1);
    send_symbol(8'hAA, 1'b0);
    send_symbol(8'h55, 1'b0);
    send_symbol(8'h0F, 1'b0);
    send_symbol(8'hF0, 1'b1);
    for (int i = 0; i < 6; i++) send_symbol(8'h3C, i == 5);
    for (int i = 0; i < 7; i++) send_symbol((i < 4) ? 8'h01 : 8'h80, i == 6);
  endtask

  // random frames; now and then a frame hitting every bin (entropy at its bound)
  task automatic test_random_frames(input idle_mode_e mode, input int n_items);
    int sent, len, alpha, base;
    idle_mode = mode;
    sent = 0;
    while (sent < n_items) begin
      if ($urandom_range(39) == 0) begin
        base = $urandom_range(255);
        for (int i = 0; i < NUM_BINS; i++) send_symbol(8'(base + i), i == NUM_BINS - 1);
        sent += NUM_BINS;
      end else begin
        len   = $urandom_range(1, 30);
        alpha = ($urandom_range(1)) ? $urandom_range(1, 8) : 256;
        base  = $urandom_range(255);
        for (int i = 0; i < len; i++)
          send_symbol(8'(base + $urandom_range(alpha - 1)), i == len - 1);
        sent += len;
      end
    end
  endtask

  // sender holds off until the block has delivered every result
  task automatic test_drain_pause();
    idle_mode = IDLE_NONE;
    for (int f = 0; f < 4; f++) begin
      @(negedge clk_i);
      s_axis_tvalid_i = 1'b0;
      wait (expected_frames.size() == 0);
      for (int i = 0; i < 5; i++) send_symbol(8'($urandom_range(255)), i == 4);
    end
  endtask

  initial begin
    foreach (hist_bins[b]) hist_bins[b] = 0;
    frame_syms = 0;
    frame_sat  = 1'b0;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    test_directed();
    test_random_frames(IDLE_NONE, 400);
    test_random_frames(IDLE_SEND, 400);
    test_drain_pause();
    test_random_frames(IDLE_RECV, 400);
    test_random_frames(IDLE_BOTH, 400);
    @(negedge clk_i);
    s_axis_tvalid_i = 1'b0;
    wait (expected_frames.size() == 0);
    repeat (200) @(posedge clk_i);
    if (error_count == 0) begin
      $display("** symbol_histogram_entropy_top: PASSED **");
    end else begin
      $display("** symbol_histogram_entropy_top: FAILED **");
    end
    $finish;
  end

endmodule

`default_nettype wire
